>>> src/bbc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Buffer cache package
// Shared constants and codes of the LRU block buffer cache.
// ----------------------------------------------------------------------------
package bbc_pkg;
   localparam int NumBuffersDefault = 32;
   localparam int DevWidth = 16;
   localparam int BlkWidth = 32;
   localparam int CountWidth = 8;
   localparam logic [CountWidth-1:0] CountMax = 8'hFF;

   localparam logic [1:0] ReqGet = 2'd0;
   localparam logic [1:0] ReqRelease = 2'd1;
   localparam logic [1:0] ReqInvalidate = 2'd2;

   localparam logic [2:0] StHit = 3'd0;
   localparam logic [2:0] StFilled = 3'd1;
   localparam logic [2:0] StNoFree = 3'd2;
   localparam logic [2:0] StReadFailed = 3'd3;
   localparam logic [2:0] StFreed = 3'd4;
   localparam logic [2:0] StHeld = 3'd5;
   localparam logic [2:0] StDone = 3'd6;
endpackage
`default_nettype wire

>>> src/block_buffer_cache_lru.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Block buffer cache with LRU order
// Pool of buffers with tags, reference counts and a linked LRU list.
// ----------------------------------------------------------------------------
// One request is handled at a time under a small sequencer that walks the
// buffers one per cycle. A get searches the tags; a hit unlinks and relinks
// the buffer, and a miss walks the LRU list from its head to a free buffer,
// then unlinks, fills and relinks it; a freeing release unlinks and relinks
// the buffer, and an invalidate scans every buffer. The result word is held
// in an output register until taken; then the next request is accepted.
module block_buffer_cache_lru
   import bbc_pkg::*;
#(
   parameter int NUM_BUFFERS = NumBuffersDefault
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  req_valid,
   output logic                 req_ready,
   input  wire  [1:0]           req_type,
   input  wire  [15:0]          req_device,
   input  wire  [31:0]          req_block_number,
   input  wire                  req_read_from_disk,
   input  wire                  req_fill_read_failed,
   input  wire  [4:0]           req_buffer_index,
   input  wire                  req_write_immediate,
   input  wire                  req_one_shot,
   input  wire                  req_mark_dirty,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic [2:0]           rsp_status,
   output logic [4:0]           rsp_buffer_out,
   output logic                 rsp_writeback_valid,
   output logic [15:0]          rsp_writeback_device,
   output logic [31:0]          rsp_writeback_block,
   output logic                 rsp_read_request,
   output logic [5:0]           rsp_in_use_count
);
   localparam int IW = $clog2(NUM_BUFFERS);
   localparam int LW = IW + 1;
   localparam int HW = $clog2(NUM_BUFFERS + 1);
   localparam logic [LW-1:0] LinkNone = LW'(NUM_BUFFERS);
   localparam logic [LW-1:0] LastIdx = LW'(NUM_BUFFERS - 1);

   typedef enum logic [3:0] {
      S_IDLE, S_SEARCH, S_WALK, S_UNLINK, S_FILL, S_LINK, S_REL, S_INVAL, S_OUT
   } state_type;

   state_type state_ff;
   logic [DevWidth-1:0] tdev_ff [NUM_BUFFERS];
   logic [BlkWidth-1:0] tblk_ff [NUM_BUFFERS];
   logic [NUM_BUFFERS-1:0] val_ff, dirty_ff;
   logic [CountWidth-1:0] cnt_ff [NUM_BUFFERS];
   logic [LW-1:0] nxt_ff [NUM_BUFFERS];
   logic [LW-1:0] prv_ff [NUM_BUFFERS];
   logic [LW-1:0] head_ff, tail_ff;
   logic [HW-1:0] held_ff;

   logic [DevWidth-1:0] dev_ff;
   logic [BlkWidth-1:0] blk_ff;
   logic rd_ff, fail_ff, wi_ff, os_ff, md_ff;
   logic [4:0] bidx_ff;
   logic [LW-1:0] cur_ff, sel_ff;
   logic [LW-1:0] steps_ff;
   logic front_ff;

   logic [IW-1:0] ci, si;
   assign ci = cur_ff[IW-1:0];
   assign si = sel_ff[IW-1:0];

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid <= 1'b0;
         val_ff <= '0;
         dirty_ff <= '0;
         head_ff <= '0;
         tail_ff <= LastIdx;
         held_ff <= '0;
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            tdev_ff[i] <= '0;
            tblk_ff[i] <= '0;
            cnt_ff[i] <= '0;
            prv_ff[i] <= (i == 0) ? LinkNone : LW'(i - 1);
            nxt_ff[i] <= (i + 1 < NUM_BUFFERS) ? LW'(i + 1) : LinkNone;
         end
      end else begin
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  dev_ff <= req_device;
                  blk_ff <= req_block_number;
                  rd_ff <= req_read_from_disk;
                  fail_ff <= req_fill_read_failed;
                  bidx_ff <= req_buffer_index;
                  wi_ff <= req_write_immediate;
                  os_ff <= req_one_shot;
                  md_ff <= req_mark_dirty;
                  cur_ff <= '0;
                  rsp_status <= StDone;
                  rsp_buffer_out <= '0;
                  rsp_writeback_valid <= 1'b0;
                  rsp_writeback_device <= '0;
                  rsp_writeback_block <= '0;
                  rsp_read_request <= 1'b0;
                  if (req_type == ReqGet) state_ff <= S_SEARCH;
                  else if (req_type == ReqRelease) state_ff <= S_REL;
                  else if (req_type == ReqInvalidate) state_ff <= S_INVAL;
                  else state_ff <= S_OUT;
               end
            end
            S_SEARCH: begin
               if (val_ff[ci] && tdev_ff[ci] == dev_ff && tblk_ff[ci] == blk_ff) begin
                  if (cnt_ff[ci] != CountMax) begin
                     if (cnt_ff[ci] == '0) held_ff <= held_ff + HW'(1);
                     cnt_ff[ci] <= cnt_ff[ci] + CountWidth'(1);
                  end
                  sel_ff <= cur_ff;
                  rsp_status <= StHit;
                  rsp_buffer_out <= 5'(cur_ff);
                  front_ff <= 1'b0;
                  state_ff <= S_UNLINK;
               end else if (cur_ff == LastIdx) begin
                  cur_ff <= head_ff;
                  steps_ff <= '0;
                  state_ff <= S_WALK;
               end else begin
                  cur_ff <= cur_ff + LW'(1);
               end
            end
            S_WALK: begin
               if (cur_ff == LinkNone || steps_ff == LW'(NUM_BUFFERS)) begin
                  rsp_status <= StNoFree;
                  state_ff <= S_OUT;
               end else if (cnt_ff[ci] == '0) begin
                  sel_ff <= cur_ff;
                  state_ff <= S_UNLINK;
                  front_ff <= 1'b0;
                  rsp_status <= StFilled;
               end else begin
                  cur_ff <= nxt_ff[ci];
                  steps_ff <= steps_ff + LW'(1);
               end
            end
            S_UNLINK: begin
               if (prv_ff[si] != LinkNone) nxt_ff[prv_ff[si][IW-1:0]] <= nxt_ff[si];
               else head_ff <= nxt_ff[si];
               if (nxt_ff[si] != LinkNone) prv_ff[nxt_ff[si][IW-1:0]] <= prv_ff[si];
               else tail_ff <= prv_ff[si];
               state_ff <= (rsp_status == StFilled) ? S_FILL : S_LINK;
            end
            S_FILL: begin
               if (val_ff[si] && dirty_ff[si]) begin
                  rsp_writeback_valid <= 1'b1;
                  rsp_writeback_device <= tdev_ff[si];
                  rsp_writeback_block <= tblk_ff[si];
               end
               dirty_ff[si] <= 1'b0;
               rsp_read_request <= rd_ff;
               if (rd_ff && fail_ff) begin
                  tdev_ff[si] <= '0;
                  tblk_ff[si] <= '0;
                  val_ff[si] <= 1'b0;
                  cnt_ff[si] <= '0;
                  front_ff <= 1'b1;
                  rsp_status <= StReadFailed;
               end else begin
                  tdev_ff[si] <= dev_ff;
                  tblk_ff[si] <= blk_ff;
                  val_ff[si] <= 1'b1;
                  cnt_ff[si] <= CountWidth'(1);
                  held_ff <= held_ff + HW'(1);
                  rsp_buffer_out <= 5'(sel_ff);
               end
               state_ff <= S_LINK;
            end
            S_LINK: begin
               if (front_ff) begin
                  prv_ff[si] <= LinkNone;
                  nxt_ff[si] <= head_ff;
                  if (head_ff != LinkNone) prv_ff[head_ff[IW-1:0]] <= sel_ff;
                  else tail_ff <= sel_ff;
                  head_ff <= sel_ff;
               end else begin
                  nxt_ff[si] <= LinkNone;
                  prv_ff[si] <= tail_ff;
                  if (tail_ff != LinkNone) nxt_ff[tail_ff[IW-1:0]] <= sel_ff;
                  else head_ff <= sel_ff;
                  tail_ff <= sel_ff;
               end
               state_ff <= S_OUT;
            end
            S_REL: begin
               if (32'(bidx_ff) >= 32'(NUM_BUFFERS) || cnt_ff[bidx_ff[IW-1:0]] == '0) begin
                  state_ff <= S_OUT;
               end else begin
                  sel_ff <= LW'(bidx_ff[IW-1:0]);
                  cnt_ff[bidx_ff[IW-1:0]] <= cnt_ff[bidx_ff[IW-1:0]] - CountWidth'(1);
                  if (cnt_ff[bidx_ff[IW-1:0]] != CountWidth'(1)) begin
                     if (md_ff && val_ff[bidx_ff[IW-1:0]]) dirty_ff[bidx_ff[IW-1:0]] <= 1'b1;
                     rsp_status <= StHeld;
                     state_ff <= S_OUT;
                  end else begin
                     if (held_ff != '0) held_ff <= held_ff - HW'(1);
                     if (val_ff[bidx_ff[IW-1:0]] && wi_ff
                         && (dirty_ff[bidx_ff[IW-1:0]] || md_ff)) begin
                        rsp_writeback_valid <= 1'b1;
                        rsp_writeback_device <= tdev_ff[bidx_ff[IW-1:0]];
                        rsp_writeback_block <= tblk_ff[bidx_ff[IW-1:0]];
                        dirty_ff[bidx_ff[IW-1:0]] <= 1'b0;
                     end else if (md_ff && val_ff[bidx_ff[IW-1:0]]) begin
                        dirty_ff[bidx_ff[IW-1:0]] <= 1'b1;
                     end
                     front_ff <= os_ff;
                     rsp_status <= StFreed;
                     state_ff <= S_UNLINK;
                  end
               end
            end
            S_INVAL: begin
               if (val_ff[ci] && tdev_ff[ci] == dev_ff) begin
                  val_ff[ci] <= 1'b0;
                  dirty_ff[ci] <= 1'b0;
                  tdev_ff[ci] <= '0;
                  tblk_ff[ci] <= '0;
               end
               if (cur_ff == LastIdx) state_ff <= S_OUT;
               else cur_ff <= cur_ff + LW'(1);
            end
            S_OUT: begin
               if (!rsp_valid) begin
                  rsp_valid <= 1'b1;
                  rsp_in_use_count <= 6'(held_ff);
               end else if (rsp_ready) begin
                  rsp_valid <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end
endmodule
`default_nettype wire
